// File: rtl/one_wire_rom_search_engine_unit_macros.svh
// Assertion macros for the 1-Wire ROM search engine.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ONE_WIRE_ROM_SEARCH_ENGINE_UNIT_MACROS_SVH
`define ONE_WIRE_ROM_SEARCH_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OWRSE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("owrse: same-cycle check failed");
`define OWRSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("owrse: next-cycle check failed");
`else
`define OWRSE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define OWRSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/owrse_pkg.sv
// Shared types, codes and the CRC-8 step for the 1-Wire ROM search engine.
// No dependencies.
package owrse_pkg;

   // request modes
   localparam logic [2:0] MODE_START_FIRST = 3'd0;
   localparam logic [2:0] MODE_START_NEXT  = 3'd1;
   localparam logic [2:0] MODE_PRESENCE    = 3'd2;
   localparam logic [2:0] MODE_BIT_PAIR    = 3'd3;
   localparam logic [2:0] MODE_TARGET      = 3'd4;
   localparam logic [2:0] MODE_FAMILY_SKIP = 3'd5;

   // response actions
   localparam logic [2:0] ACT_ISSUE_RESET  = 3'd0;
   localparam logic [2:0] ACT_WRITE_CMD    = 3'd1;
   localparam logic [2:0] ACT_WRITE_DIR    = 3'd2;
   localparam logic [2:0] ACT_SEARCH_DONE  = 3'd3;
   localparam logic [2:0] ACT_SETUP_DONE   = 3'd4;

   localparam logic [7:0] SEARCH_CMD_RESET = 8'hF0;
   localparam logic [7:0] CRC_POLY         = 8'h8C;
   localparam logic [6:0] BIT_LAST         = 7'd64;
   localparam logic [6:0] FAMILY_LIMIT     = 7'd9;
   localparam logic [6:0] TARGET_DISCREP   = 7'd64;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  command_byte;
      logic        direction;
      logic        found;
      logic [63:0] rom_code;
      logic        last_device;
   } result_type;

   // Dallas CRC-8, one byte, LSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       mix;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ data[i];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/owrse_if.sv
// Valid/ready channel interfaces for the 1-Wire ROM search engine.
// No dependencies.
interface owrse_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       device_absent;
   logic       id_bit;
   logic       complement_bit;
   logic [7:0] target_family;
   modport source (output valid, mode, device_absent, id_bit, complement_bit, target_family,
                   input ready);
   modport sink   (input valid, mode, device_absent, id_bit, complement_bit, target_family,
                   output ready);
endinterface

interface owrse_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  command_byte;
   logic        direction;
   logic        found;
   logic [63:0] rom_code;
   logic        last_device;
   modport source (output valid, action, command_byte, direction, found, rom_code,
                   last_device, input ready);
   modport sink   (input valid, action, command_byte, direction, found, rom_code,
                   last_device, output ready);
endinterface

interface owrse_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/one_wire_rom_search_engine_unit.sv
// 1-Wire ROM search engine: one event per transfer, results through a small queue.
// State updates at the request transfer edge, where its results are written into the queue.
// Throughput: one request per cycle; the final bit pair yields two results, so the
// response queue (RSP_DEPTH entries) throttles requests when fewer than two slots are free.
// Reset (sync, active high): search state cleared, bit position 1, queue empty, cmd 0xF0.
// Depends on owrse_pkg, owrse_if and the assertion macro header.
`include "one_wire_rom_search_engine_unit_macros.svh"

module one_wire_rom_search_engine_unit #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   owrse_req_if.sink     req_chan,
   owrse_rsp_if.source   rsp_chan,
   owrse_csr_if.sink     csr_chan
);

   localparam int unsigned PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] READY_MAX = CNT_W'(RSP_DEPTH - 2);

   typedef enum logic [1:0] {PH_IDLE, PH_PRESENCE, PH_BITS} phase_type;

   // search state
   phase_type   phase_ff, phase_in;
   logic [63:0] rom_ff, rom_in;
   logic [6:0]  last_disc_ff, last_disc_in;
   logic [6:0]  fam_disc_ff, fam_disc_in;
   logic        last_dev_ff, last_dev_in;
   logic [6:0]  bit_pos_ff, bit_pos_in;
   logic [6:0]  zero_mark_ff, zero_mark_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  search_cmd_ff;

   // response queue
   owrse_pkg::result_type fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PTR_W-1:0] head_plus1, tail_plus1, tail_plus2;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                  req_xfer, rsp_xfer;
   logic                  push_first, push_second;
   owrse_pkg::result_type res_first, res_second;
   logic [5:0]            pos;
   logic                  dir;
   logic                  ok;
   logic                  chk_pos_ok, chk_found_ok;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (count_ff <= READY_MAX);
   assign csr_chan.ready = 1'b1;

   assign head_plus1 = (head_ff == LAST_PTR) ? '0 : head_ff + PTR_W'(1);
   assign tail_plus1 = (tail_ff == LAST_PTR) ? '0 : tail_ff + PTR_W'(1);
   assign tail_plus2 = (tail_plus1 == LAST_PTR) ? '0 : tail_plus1 + PTR_W'(1);

   assign pos = 6'(bit_pos_ff - 7'd1);

   always_comb begin
      phase_in     = phase_ff;
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      bit_pos_in   = bit_pos_ff;
      zero_mark_in = zero_mark_ff;
      crc_in       = crc_ff;
      res_first    = '0;
      res_second   = '0;
      push_first   = 1'b0;
      push_second  = 1'b0;
      dir          = 1'b0;
      ok           = 1'b0;

      if (req_xfer) begin
         unique case (req_chan.mode)
            owrse_pkg::MODE_START_FIRST, owrse_pkg::MODE_START_NEXT: begin
               bit_pos_in   = 7'd1;
               zero_mark_in = '0;
               crc_in       = '0;
               push_first   = 1'b1;
               if (req_chan.mode == owrse_pkg::MODE_START_NEXT && last_dev_ff) begin
                  // nothing left to find: report done without bus activity
                  last_disc_in         = '0;
                  fam_disc_in          = '0;
                  last_dev_in          = 1'b0;
                  phase_in             = PH_IDLE;
                  res_first.action     = owrse_pkg::ACT_SEARCH_DONE;
                  res_first.rom_code   = rom_ff;
               end else begin
                  if (req_chan.mode == owrse_pkg::MODE_START_FIRST) begin
                     last_disc_in = '0;
                     fam_disc_in  = '0;
                     last_dev_in  = 1'b0;
                  end
                  phase_in         = PH_PRESENCE;
                  res_first.action = owrse_pkg::ACT_ISSUE_RESET;
               end
            end
            owrse_pkg::MODE_PRESENCE: begin
               if (phase_ff == PH_PRESENCE) begin
                  push_first = 1'b1;
                  if (req_chan.device_absent) begin
                     last_disc_in       = '0;
                     fam_disc_in        = '0;
                     last_dev_in        = 1'b0;
                     phase_in           = PH_IDLE;
                     res_first.action   = owrse_pkg::ACT_SEARCH_DONE;
                     res_first.rom_code = rom_ff;
                  end else begin
                     phase_in               = PH_BITS;
                     res_first.action       = owrse_pkg::ACT_WRITE_CMD;
                     res_first.command_byte = search_cmd_ff;
                  end
               end
            end
            owrse_pkg::MODE_BIT_PAIR: begin
               if (phase_ff == PH_BITS) begin
                  push_first = 1'b1;
                  if (req_chan.id_bit && req_chan.complement_bit) begin
                     // no device answered: search fails short of 64 bits
                     last_disc_in       = '0;
                     fam_disc_in        = '0;
                     last_dev_in        = 1'b0;
                     phase_in           = PH_IDLE;
                     res_first.action   = owrse_pkg::ACT_SEARCH_DONE;
                     res_first.rom_code = rom_ff;
                  end else begin
                     if (req_chan.id_bit != req_chan.complement_bit) begin
                        dir = req_chan.id_bit;
                     end else begin
                        if (bit_pos_ff < last_disc_ff) begin
                           dir = rom_ff[pos];
                        end else begin
                           dir = (bit_pos_ff == last_disc_ff);
                        end
                        if (!dir) begin
                           zero_mark_in = bit_pos_ff;
                           if (bit_pos_ff < owrse_pkg::FAMILY_LIMIT) begin
                              fam_disc_in = bit_pos_ff;
                           end
                        end
                     end
                     rom_in[pos]         = dir;
                     res_first.action    = owrse_pkg::ACT_WRITE_DIR;
                     res_first.direction = dir;
                     if (pos[2:0] == 3'd7) begin
                        crc_in = owrse_pkg::crc8_byte(crc_ff,
                                                      rom_in[{pos[5:3], 3'b000} +: 8]);
                     end
                     bit_pos_in = bit_pos_ff + 7'd1;
                     if (bit_pos_ff == owrse_pkg::BIT_LAST) begin
                        // last bit: second result closes the search
                        push_second = 1'b1;
                        phase_in    = PH_IDLE;
                        ok          = (crc_in == 8'd0);
                        if (ok) begin
                           last_disc_in = zero_mark_in;
                           last_dev_in  = last_dev_ff | (zero_mark_in == 7'd0);
                        end
                        if (!ok || rom_in[7:0] == 8'd0) begin
                           ok           = 1'b0;
                           last_disc_in = '0;
                           fam_disc_in  = '0;
                           last_dev_in  = 1'b0;
                        end
                        res_second.action      = owrse_pkg::ACT_SEARCH_DONE;
                        res_second.found       = ok;
                        res_second.rom_code    = rom_in;
                        res_second.last_device = last_dev_in;
                     end
                  end
               end
            end
            owrse_pkg::MODE_TARGET: begin
               phase_in         = PH_IDLE;
               rom_in           = {56'd0, req_chan.target_family};
               last_disc_in     = owrse_pkg::TARGET_DISCREP;
               fam_disc_in      = '0;
               last_dev_in      = 1'b0;
               push_first       = 1'b1;
               res_first.action = owrse_pkg::ACT_SETUP_DONE;
            end
            owrse_pkg::MODE_FAMILY_SKIP: begin
               phase_in         = PH_IDLE;
               last_disc_in     = fam_disc_ff;
               fam_disc_in      = '0;
               if (fam_disc_ff == 7'd0) begin
                  last_dev_in = 1'b1;
               end
               push_first       = 1'b1;
               res_first.action = owrse_pkg::ACT_SETUP_DONE;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      head_in = rsp_xfer ? head_plus1 : head_ff;
      if (push_second) begin
         tail_in = tail_plus2;
      end else if (push_first) begin
         tail_in = tail_plus1;
      end else begin
         tail_in = tail_ff;
      end
      count_in = count_ff + CNT_W'(push_first) + CNT_W'(push_second) - CNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         rom_ff        <= '0;
         last_disc_ff  <= '0;
         fam_disc_ff   <= '0;
         last_dev_ff   <= 1'b0;
         bit_pos_ff    <= 7'd1;
         zero_mark_ff  <= '0;
         crc_ff        <= '0;
         search_cmd_ff <= owrse_pkg::SEARCH_CMD_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         fam_disc_ff  <= fam_disc_in;
         last_dev_ff  <= last_dev_in;
         bit_pos_ff   <= bit_pos_in;
         zero_mark_ff <= zero_mark_in;
         crc_ff       <= crc_in;
         if (csr_chan.valid && csr_chan.ready) begin
            search_cmd_ff <= csr_chan.data;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         fifo_ff[tail_ff] <= res_first;
      end
      if (push_second) begin
         fifo_ff[tail_plus1] <= res_second;
      end
   end

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.action       = fifo_ff[head_ff].action;
   assign rsp_chan.command_byte = fifo_ff[head_ff].command_byte;
   assign rsp_chan.direction    = fifo_ff[head_ff].direction;
   assign rsp_chan.found        = fifo_ff[head_ff].found;
   assign rsp_chan.rom_code     = fifo_ff[head_ff].rom_code;
   assign rsp_chan.last_device  = fifo_ff[head_ff].last_device;

   assign chk_pos_ok   = (bit_pos_ff >= 7'd1) && (bit_pos_ff <= owrse_pkg::BIT_LAST);
   assign chk_found_ok = (rsp_chan.action == owrse_pkg::ACT_SEARCH_DONE) &&
                         (rsp_chan.rom_code[7:0] != 8'd0);

   // a request transfer always finds room for two results
   `OWRSE_ASSERT_NOW(a_room_on_xfer, clock, reset, req_xfer, count_ff <= READY_MAX)
   // the final bit pair ends the search and leaves a result waiting
   `OWRSE_ASSERT_NEXT(a_last_bit_ends, clock, reset, push_second, phase_ff == PH_IDLE && count_ff != '0)
   // while reading bits the position stays within the ROM code
   `OWRSE_ASSERT_NOW(a_bit_pos_range, clock, reset, phase_ff == PH_BITS, chk_pos_ok)
   // a found device always has a nonzero family byte and comes with search done
   `OWRSE_ASSERT_NOW(a_found_valid, clock, reset, rsp_chan.valid && rsp_chan.found, chk_found_ok)

endmodule

// File: tb/testbench.sv
// Self-checking bench for one_wire_rom_search_engine_unit: simulated buses with random
// device codes are searched over valid/ready channels and every response is predicted.
// Depends on owrse_pkg, owrse_if and the engine RTL.
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
   localparam logic [6:0] BIT_PAST_END  = 7'd65;
   localparam int PHASE_ITEMS   = 180;
   localparam int LONG_STALL    = 400;
   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 4;

   typedef enum logic [1:0] {
      SP_IDLE          = 2'd0,
      SP_WAIT_PRESENCE = 2'd1,
      SP_READ_BITS     = 2'd2
   } search_phase_type;

   typedef struct packed {
      logic [63:0]      rom;
      logic [6:0]       last_disc;
      logic [6:0]       fam_disc;
      logic             last_dev;
      logic [6:0]       bit_pos;
      logic [6:0]       zero_mark;
      logic [7:0]       crc;
      search_phase_type phase;
   } search_state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       device_absent;
      logic       id_bit;
      logic       complement_bit;
      logic [7:0] target_family;
   } req_item_type;

   logic clock = 1'b0;
   logic reset;

   owrse_req_if req_chan ();
   owrse_rsp_if rsp_chan ();
   owrse_csr_if csr_chan ();

   one_wire_rom_search_engine_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   search_state_type      live_search;   // tracks the engine as requests transfer
   search_state_type      plan_search;   // tracks the engine while stimulus is generated
   logic [7:0]            cmd_setting;
   req_item_type          send_q [$];
   owrse_pkg::result_type due_responses [$];
   int                    mismatch_count = 0;
   int                    phase_items;
   int                    stall_requests = 0;

   logic [63:0]   bus_dev [4];
   int            bus_count;

   // ---------------------------------------------------------------- prediction

   function automatic search_state_type idle_search();
      search_state_type s;
      s = '0;
      s.bit_pos = 7'd1;
      s.phase = SP_IDLE;
      return s;
   endfunction

   function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      int         k;
      c = acc;
      for (k = 0; k < 8; k++) begin
         if (c[0] ^ b[k]) c = (c >> 1) ^ owrse_pkg::CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic owrse_pkg::result_type close_search(inout search_state_type s,
                                                          input bit ran);
      owrse_pkg::result_type r;
      bit                    ok;
      ok = ran && (s.bit_pos >= BIT_PAST_END) && (s.crc == 8'h00);
      if (ok) begin
         s.last_disc = s.zero_mark;
         if (s.last_disc == 7'd0) s.last_dev = 1'b1;
      end
      if (!ok || s.rom[7:0] == 8'h00) begin
         s.last_disc = '0;
         s.fam_disc = '0;
         s.last_dev = 1'b0;
         ok = 1'b0;
      end
      s.phase = SP_IDLE;
      r = '0;
      r.action = owrse_pkg::ACT_SEARCH_DONE;
      r.found = ok;
      r.rom_code = s.rom;
      r.last_device = s.last_dev;
      return r;
   endfunction

   // applies one request; returns how many responses it causes
   function automatic int step_search(inout search_state_type s, input req_item_type it,
                                      input logic [7:0] cmd,
                                      output owrse_pkg::result_type r0,
                                      output owrse_pkg::result_type r1);
      logic [6:0] pos_m1;
      logic [5:0] pos;
      logic       dir;
      r0 = '0;
      r1 = '0;
      case (it.mode)
         owrse_pkg::MODE_START_FIRST, owrse_pkg::MODE_START_NEXT: begin
            if (it.mode == owrse_pkg::MODE_START_FIRST) begin
               s.last_disc = '0;
               s.fam_disc = '0;
               s.last_dev = 1'b0;
            end
            s.bit_pos = 7'd1;
            s.zero_mark = '0;
            s.crc = '0;
            if (s.last_dev) begin
               r0 = close_search(s, 1'b0);
               return 1;
            end
            s.phase = SP_WAIT_PRESENCE;
            r0.action = owrse_pkg::ACT_ISSUE_RESET;
            return 1;
         end
         owrse_pkg::MODE_PRESENCE: begin
            if (s.phase != SP_WAIT_PRESENCE) return 0;
            if (it.device_absent) begin
               r0 = close_search(s, 1'b0);
               return 1;
            end
            s.phase = SP_READ_BITS;
            r0.action = owrse_pkg::ACT_WRITE_CMD;
            r0.command_byte = cmd;
            return 1;
         end
         owrse_pkg::MODE_BIT_PAIR: begin
            if (s.phase != SP_READ_BITS) return 0;
            if (it.id_bit && it.complement_bit) begin
               r0 = close_search(s, 1'b1);
               return 1;
            end
            pos_m1 = s.bit_pos - 7'd1;
            pos = pos_m1[5:0];
            if (it.id_bit != it.complement_bit) begin
               dir = it.id_bit;
            end else begin
               // discrepancy: follow the previous path below the last one, take 1 at it
               if (s.bit_pos < s.last_disc) dir = s.rom[pos];
               else dir = (s.bit_pos == s.last_disc);
               if (!dir) begin
                  s.zero_mark = s.bit_pos;
                  if (s.zero_mark < owrse_pkg::FAMILY_LIMIT) s.fam_disc = s.zero_mark;
               end
            end
            s.rom[pos] = dir;
            r0.action = owrse_pkg::ACT_WRITE_DIR;
            r0.direction = dir;
            if (pos[2:0] == 3'd7) s.crc = crc8_update(s.crc, s.rom[{pos[5:3], 3'b000} +: 8]);
            s.bit_pos = s.bit_pos + 7'd1;
            if (pos == 6'd63) begin
               s.bit_pos = BIT_PAST_END;
               r1 = close_search(s, 1'b1);
               return 2;
            end
            return 1;
         end
         owrse_pkg::MODE_TARGET: begin
            s.phase = SP_IDLE;
            s.rom = {56'd0, it.target_family};
            s.last_disc = owrse_pkg::TARGET_DISCREP;
            s.fam_disc = '0;
            s.last_dev = 1'b0;
            r0.action = owrse_pkg::ACT_SETUP_DONE;
            return 1;
         end
         owrse_pkg::MODE_FAMILY_SKIP: begin
            s.phase = SP_IDLE;
            s.last_disc = s.fam_disc;
            s.fam_disc = '0;
            if (s.last_disc == 7'd0) s.last_dev = 1'b1;
            r0.action = owrse_pkg::ACT_SETUP_DONE;
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_item_type rand_item(input logic [2:0] m);
      req_item_type it;
      it.mode = m;
      it.device_absent = 1'($urandom_range(0, 1));
      it.id_bit = 1'($urandom_range(0, 1));
      it.complement_bit = 1'($urandom_range(0, 1));
      it.target_family = 8'($urandom_range(0, 255));
      return it;
   endfunction

   task automatic queue_item(input req_item_type it, output int n,
                             output owrse_pkg::result_type r0,
                             output owrse_pkg::result_type r1);
      n = step_search(plan_search, it, cmd_setting, r0, r1);
      send_q.push_back(it);
      phase_items++;
   endtask

   task automatic queue_fields(input logic [2:0] m, input logic absent, input logic idb,
                               input logic cmpb, input logic [7:0] fam);
      req_item_type          it;
      int                    n;
      owrse_pkg::result_type r0, r1;
      it.mode = m;
      it.device_absent = absent;
      it.id_bit = idb;
      it.complement_bit = cmpb;
      it.target_family = fam;
      queue_item(it, n, r0, r1);
   endtask

   task automatic build_bus();
      logic [7:0] fam_a, fam_b, acc;
      int         d, k;
      bus_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      fam_a = 8'($urandom_range(1, 255));
      fam_b = $urandom_range(0, 1) ? fam_a : 8'($urandom_range(1, 255));
      for (d = 0; d < 4; d++) begin
         bus_dev[d][7:0] = $urandom_range(0, 1) ? fam_a : fam_b;
         if (d > 0 && $urandom_range(0, 1)) begin
            // near twin of device 0: forces a deep discrepancy
            bus_dev[d][55:8] = bus_dev[0][55:8];
            k = $urandom_range(8, 55);
            bus_dev[d][k] = ~bus_dev[d][k];
         end else begin
            bus_dev[d][39:8] = $urandom;
            bus_dev[d][55:40] = 16'($urandom_range(0, 65535));
         end
         if ($urandom_range(0, 19) == 0) bus_dev[d][7:0] = 8'h00;
         acc = 8'h00;
         for (k = 0; k < 7; k++) acc = crc8_update(acc, bus_dev[d][k*8 +: 8]);
         bus_dev[d][63:56] = acc;
         if ($urandom_range(0, 11) == 0) begin
            k = $urandom_range(0, 63);
            bus_dev[d][k] = ~bus_dev[d][k];
         end
      end
   endtask

   // one search over the current bus; more is set when another search should follow
   task automatic run_search(input logic [2:0] start_mode, output bit more);
      req_item_type          it;
      int                    n, k, pos, abort_at;
      owrse_pkg::result_type r0, r1;
      logic [3:0]            active;
      logic                  idb, cmpb;
      more = 1'b0;
      abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : 64;
      queue_item(rand_item(start_mode), n, r0, r1);
      if (r0.action == owrse_pkg::ACT_SEARCH_DONE) return;
      it = rand_item(owrse_pkg::MODE_PRESENCE);
      it.device_absent = (bus_count == 0);
      if ($urandom_range(0, 29) == 0) it.device_absent = ~it.device_absent;
      queue_item(it, n, r0, r1);
      if (r0.action == owrse_pkg::ACT_SEARCH_DONE) return;
      active = 4'b1111;
      for (pos = 0; pos < 64; pos++) begin
         // an early stop leaves the search open; the next start abandons it
         if (pos == abort_at || phase_items >= PHASE_ITEMS) return;
         idb = 1'b1;
         cmpb = 1'b1;
         // wired-AND bus: any active device pulls the slot low
         for (k = 0; k < bus_count; k++) begin
            if (active[k]) begin
               idb = idb & bus_dev[k][pos];
               cmpb = cmpb & ~bus_dev[k][pos];
            end
         end
         if ($urandom_range(0, 99) == 0) begin
            if ($urandom_range(0, 1)) idb = ~idb;
            else cmpb = ~cmpb;
         end
         it = rand_item(owrse_pkg::MODE_BIT_PAIR);
         it.id_bit = idb;
         it.complement_bit = cmpb;
         queue_item(it, n, r0, r1);
         if (r0.action == owrse_pkg::ACT_SEARCH_DONE) return;
         for (k = 0; k < 4; k++) begin
            if (bus_dev[k][pos] != r0.direction) active[k] = 1'b0;
         end
         if (n == 2) begin
            more = r1.found && !r1.last_device;
            return;
         end
      end
   endtask

   task automatic enumerate_bus();
      logic [2:0]            start_mode;
      req_item_type          it;
      int                    n, searches;
      owrse_pkg::result_type r0, r1;
      bit                    more;
      build_bus();
      start_mode = owrse_pkg::MODE_START_FIRST;
      if ($urandom_range(0, 4) == 0) begin
         it = rand_item(owrse_pkg::MODE_TARGET);
         if (bus_count > 0) begin
            it.target_family = bus_dev[$urandom_range(0, bus_count - 1)][7:0];
         end
         queue_item(it, n, r0, r1);
         start_mode = owrse_pkg::MODE_START_NEXT;
      end
      for (searches = 0; searches < 6; searches++) begin
         run_search(start_mode, more);
         if (!more || phase_items >= PHASE_ITEMS) break;
         if ($urandom_range(0, 6) == 0) begin
            queue_item(rand_item(owrse_pkg::MODE_FAMILY_SKIP), n, r0, r1);
         end
         start_mode = owrse_pkg::MODE_START_NEXT;
      end
      if ($urandom_range(0, 2) == 0) queue_item(rand_item(owrse_pkg::MODE_START_NEXT), n, r0, r1);
   endtask

   task automatic add_noise();
      int                    j, n;
      owrse_pkg::result_type r0, r1;
      for (j = $urandom_range(1, 4); j > 0; j--) begin
         queue_item(rand_item(3'($urandom_range(0, 7))), n, r0, r1);
      end
   endtask

   // ---------------------------------------------------------------- sequencing

   task automatic wait_drained();
      while (send_q.size() != 0 || req_chan.valid || due_responses.size() != 0) begin
         @(posedge clock);
         #1;
      end
      // ignored requests give no response but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_search_command(input logic [7:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      do begin
         @(posedge clock);
      end while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      cmd_setting = value;
      #1;
   endtask

   task automatic report_mismatch(input string what, input owrse_pkg::result_type want,
                                  input owrse_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected act %0d cmd %h dir %b found %b rom %h last %b",
                  what, want.action, want.command_byte, want.direction, want.found,
                  want.rom_code, want.last_device);
         $display("   actual: act %0d cmd %h dir %b found %b rom %h last %b",
                  got.action, got.command_byte, got.direction, got.found,
                  got.rom_code, got.last_device);
      end
   endtask

   initial begin
      int ph;
      req_chan.valid = 1'b0;
      req_chan.mode = owrse_pkg::MODE_START_FIRST;
      req_chan.device_absent = 1'b0;
      req_chan.id_bit = 1'b0;
      req_chan.complement_bit = 1'b0;
      req_chan.target_family = 8'h00;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = 8'h00;
      live_search = idle_search();
      plan_search = idle_search();
      cmd_setting = owrse_pkg::SEARCH_CMD_RESET;
      phase_items = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset command byte
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b1, 8'h00);  // bit pair while idle
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b0, 1'b1, 1'b0, 8'hFF);  // presence while idle
      queue_fields(MODE_UNUSED_6, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_fields(MODE_UNUSED_7, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_START_FIRST, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b1, 1'b0, 1'b0, 8'h00);  // no presence pulse
      queue_fields(owrse_pkg::MODE_START_NEXT, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b0, 1'b1, 1'b1, 8'hAA);
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b0, 1'b0, 1'b0, 8'h55);  // presence during bits
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b1, 1'b0, 1'b1, 8'h00);
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b1, 1'b0, 8'hFF);
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b1, 1'b1, 8'h00);  // all-ones pair
      queue_fields(owrse_pkg::MODE_START_FIRST, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_START_NEXT, 1'b0, 1'b0, 1'b0, 8'h00); // restart mid-search
      queue_fields(owrse_pkg::MODE_PRESENCE, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00);
      queue_fields(owrse_pkg::MODE_TARGET, 1'b1, 1'b1, 1'b1, 8'hFF);     // setup mid-search
      queue_fields(owrse_pkg::MODE_TARGET, 1'b0, 1'b0, 1'b0, 8'h00);
      // nothing left after the skip: last device
      queue_fields(owrse_pkg::MODE_FAMILY_SKIP, 1'b0, 1'b0, 1'b0, 8'h00);
      // start after last device
      queue_fields(owrse_pkg::MODE_START_NEXT, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_fields(owrse_pkg::MODE_FAMILY_SKIP, 1'b1, 1'b1, 1'b1, 8'hFF);
      queue_fields(owrse_pkg::MODE_START_FIRST, 1'b0, 1'b0, 1'b0, 8'h00);
      wait_drained();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_search_command(8'h00);
            1: write_search_command(8'hFF);
            2: write_search_command(8'($urandom_range(0, 255)));
            default: write_search_command(owrse_pkg::SEARCH_CMD_RESET);
         endcase
         if (ph == 1) stall_requests++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) enumerate_bus();
            else add_noise();
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ---------------------------------------------------------------- request driver

   req_item_type on_wire;
   int           req_gap = 0;
   bit           req_burst = 1'b0;

   always @(posedge clock) begin : request_driver
      owrse_pkg::result_type r0, r1;
      int                    n;
      logic                  next_valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         next_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            n = step_search(live_search, on_wire, cmd_setting, r0, r1);
            if (n > 0) due_responses.push_back(r0);
            if (n > 1) due_responses.push_back(r1);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (send_q.size() > 0) begin
               on_wire = send_q.pop_front();
               next_valid = 1'b1;
               req_chan.mode <= on_wire.mode;
               req_chan.device_absent <= on_wire.device_absent;
               req_chan.id_bit <= on_wire.id_bit;
               req_chan.complement_bit <= on_wire.complement_bit;
               req_chan.target_family <= on_wire.target_family;
               if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
               req_gap = req_burst ? 0 : $urandom_range(0, 10);
            end
         end
         req_chan.valid <= next_valid;
      end
   end

   // ---------------------------------------------------------------- response monitor

   int rsp_gap = 0;
   int stall_left = 0;
   int stalls_served = 0;
   bit rsp_burst = 1'b0;

   always @(posedge clock) begin : response_monitor
      owrse_pkg::result_type got, want;
      logic                  next_ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.action = rsp_chan.action;
            got.command_byte = rsp_chan.command_byte;
            got.direction = rsp_chan.direction;
            got.found = rsp_chan.found;
            got.rom_code = rsp_chan.rom_code;
            got.last_device = rsp_chan.last_device;
            if (due_responses.size() == 0) begin
               report_mismatch("unexpected response", '0, got);
            end else begin
               want = due_responses.pop_front();
               if (got.action !== want.action || got.command_byte !== want.command_byte ||
                   got.direction !== want.direction || got.found !== want.found ||
                   got.rom_code !== want.rom_code || got.last_device !== want.last_device)
                  report_mismatch("response mismatch", want, got);
            end
            if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, 10);
         end
         if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // ---------------------------------------------------------------- watchdog

   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
                   (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/owrse_pkg.sv
rtl/owrse_if.sv
rtl/one_wire_rom_search_engine_unit.sv
tb/testbench.sv
